### sv/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int PORT_PRIO_WIDTH = 8;
   localparam int OCC_WIDTH = 5;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } spq_status_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic remove;
   } spq_op_type;

endpackage

### sv/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; #(
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spq_op_type                op,
   input  logic [VALUE_WIDTH-1:0]    new_value,
   input  logic [PRIORITY_WIDTH-1:0] new_prio,
   input  logic                      left_valid,
   input  logic [VALUE_WIDTH-1:0]    left_value,
   input  logic [PRIORITY_WIDTH-1:0] left_prio,
   input  logic                      left_ge,
   input  logic                      right_valid,
   input  logic [VALUE_WIDTH-1:0]    right_value,
   input  logic [PRIORITY_WIDTH-1:0] right_prio,
   output logic                      valid,
   output logic [VALUE_WIDTH-1:0]    value,
   output logic [PRIORITY_WIDTH-1:0] prio,
   output logic                      ge
);

   logic                      valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]    value_ff, value_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;

   // Entries are sorted and packed toward the front, so this flag is a
   // thermometer along the chain; the new entry lands at its first zero.
   assign ge = valid_ff && (prio_ff >= new_prio);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (op.insert) begin
         if (!ge) begin
            if (left_ge) begin
               valid_in = 1'b1;
               value_in = new_value;
               prio_in  = new_prio;
            end else begin
               valid_in = left_valid;
               value_in = left_value;
               prio_in  = left_prio;
            end
         end
      end else if (op.remove) begin
         valid_in = right_valid;
         value_in = right_value;
         prio_in  = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

### sv/stable_priority_queue_top.sv
// Top level of the stable priority queue built from a chain of sorting cells.
// Latency: the response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_ready drains responses; every cell updates in parallel each cycle.
// While a response waits, a new request is taken only if that response leaves in the same cycle.
// Reset empties the queue and drops any pending response; stored payloads are not cleared.
module stable_priority_queue_top import spq_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic signed [VALUE_WIDTH-1:0]     req_value,
   input  logic [PORT_PRIO_WIDTH-1:0]        req_priority_req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [VALUE_WIDTH-1:0]     rsp_removed_value,
   output logic [PORT_PRIO_WIDTH-1:0]        rsp_removed_priority,
   output logic [OCC_WIDTH-1:0]              rsp_occupancy
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic                      accept;
   logic                      full;
   logic                      empty;
   spq_op_type                op;
   logic [31:0]               req_prio_ext;
   logic [PRIORITY_WIDTH-1:0] new_prio;
   logic [31:0]               front_prio_ext;
   logic [31:0]               count_ext;

   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   spq_status_type            status_ff, status_in;
   logic [VALUE_WIDTH-1:0]    removed_value_ff, removed_value_in;
   logic [PORT_PRIO_WIDTH-1:0] removed_priority_ff, removed_priority_in;
   logic [OCC_WIDTH-1:0]      occupancy_ff, occupancy_in;

   logic [CAPACITY-1:0]       cell_valid;
   logic [CAPACITY-1:0]       cell_ge;
   logic [VALUE_WIDTH-1:0]    cell_value [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] cell_prio [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign op.insert = accept && (req_mode == MODE_INSERT) && !full;
   assign op.remove = accept && (req_mode == MODE_REMOVE) && !empty;

   // Priorities are kept modulo 2^PRIORITY_WIDTH.
   assign req_prio_ext   = 32'(req_priority_req);
   assign new_prio       = req_prio_ext[PRIORITY_WIDTH-1:0];
   assign front_prio_ext = 32'(cell_prio[0]);

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                      l_valid;
         logic [VALUE_WIDTH-1:0]    l_value;
         logic [PRIORITY_WIDTH-1:0] l_prio;
         logic                      l_ge;
         logic                      r_valid;
         logic [VALUE_WIDTH-1:0]    r_value;
         logic [PRIORITY_WIDTH-1:0] r_prio;

         if (i == 0) begin : g_front
            // The front cell sees a virtual neighbor that always outranks.
            assign l_valid = 1'b0;
            assign l_value = '0;
            assign l_prio  = '0;
            assign l_ge    = 1'b1;
         end else begin : g_mid_left
            assign l_valid = cell_valid[i-1];
            assign l_value = cell_value[i-1];
            assign l_prio  = cell_prio[i-1];
            assign l_ge    = cell_ge[i-1];
         end

         if (i == CAPACITY - 1) begin : g_back
            assign r_valid = 1'b0;
            assign r_value = '0;
            assign r_prio  = '0;
         end else begin : g_mid_right
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
            assign r_prio  = cell_prio[i+1];
         end

         spq_cell #(
            .PRIORITY_WIDTH(PRIORITY_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .new_value   (req_value),
            .new_prio    (new_prio),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .left_prio   (l_prio),
            .left_ge     (l_ge),
            .right_valid (r_valid),
            .right_value (r_value),
            .right_prio  (r_prio),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i]),
            .ge          (cell_ge[i])
         );
      end
   endgenerate

   always_comb begin
      count_in            = count_ff;
      rsp_valid_in        = rsp_valid_ff;
      status_in           = status_ff;
      removed_value_in    = removed_value_ff;
      removed_priority_in = removed_priority_ff;

      if (op.insert) begin
         count_in = count_ff + CW'(1);
      end else if (op.remove) begin
         count_in = count_ff - CW'(1);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in        = 1'b1;
         removed_value_in    = '0;
         removed_priority_in = '0;
         if (req_mode == MODE_REMOVE) begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in           = ST_REMOVED;
               removed_value_in    = cell_value[0];
               removed_priority_in = front_prio_ext[PORT_PRIO_WIDTH-1:0];
            end
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
         end
      end
   end

   assign count_ext    = 32'(count_in);
   assign occupancy_in = accept ? count_ext[OCC_WIDTH-1:0] : occupancy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff           <= status_in;
      removed_value_ff    <= removed_value_in;
      removed_priority_ff <= removed_priority_in;
      occupancy_ff        <= occupancy_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_value    = removed_value_ff;
   assign rsp_removed_priority = removed_priority_ff;
   assign rsp_occupancy        = occupancy_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("occupied cells disagree with entry count");

   a_remove_response: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_REMOVE) && !empty |=>
         rsp_valid_ff && (status_ff == ST_REMOVED))
      else $error("remove from a nonempty queue did not report a removal");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] && cell_valid[1] |-> cell_prio[0] >= cell_prio[1])
      else $error("front cells out of order");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      empty |-> !cell_valid[0])
      else $error("front cell holds an entry while the queue is empty");

endmodule
